[rtl/meeting_room_allocator_macros.svh]
// ----------------------------------------------------------------------------
// Meeting room allocator assertion macros
// Shared helpers for concurrent assertions, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef MEETING_ROOM_ALLOCATOR_MACROS_SVH
`define MEETING_ROOM_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define MRA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is low
`define MRA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/mra_pkg.sv]
// ----------------------------------------------------------------------------
// Meeting room allocator package
// Widths, error codes, sequencer states and store control shared by the RTL.
// ----------------------------------------------------------------------------
package mra_pkg;

	localparam int TIME_W = 40;
	localparam int CNT_W  = 32;
	localparam int REQ_W  = 32;
	localparam int RC_W   = 5;

	localparam logic [TIME_W-1:0] TIME_MAX = '1;
	localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

	localparam logic [RC_W-1:0] ROOM_COUNT_RST = 5'd16;

	// error codes
	localparam logic [1:0] ERR_OK    = 2'd0;
	localparam logic [1:0] ERR_EMPTY = 2'd1;
	localparam logic [1:0] ERR_ORDER = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CALC,
		ST_UPDATE,
		ST_MSCAN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic wr;
		logic clr;
	} store_ctl_t;

endpackage

[rtl/mra_room_store.sv]
// ----------------------------------------------------------------------------
// Room store
// Free time and meeting count per room, one write and one registered read
// a cycle. Per-room valid bits make unwritten or cleared rooms read as zero.
// ----------------------------------------------------------------------------
module mra_room_store #(
	parameter int NUM_ROOMS = 16,
	localparam int IW = (NUM_ROOMS > 1) ? $clog2(NUM_ROOMS) : 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  mra_pkg::store_ctl_t        ctl,
	input  logic [IW-1:0]              rd_addr,
	input  logic [IW-1:0]              wr_addr,
	input  logic [mra_pkg::TIME_W-1:0] wr_free,
	input  logic [mra_pkg::CNT_W-1:0]  wr_count,
	output logic [mra_pkg::TIME_W-1:0] rd_free,
	output logic [mra_pkg::CNT_W-1:0]  rd_count
);
	import mra_pkg::*;

	logic [TIME_W-1:0]    free_mem  [NUM_ROOMS];
	logic [CNT_W-1:0]     count_mem [NUM_ROOMS];
	logic [NUM_ROOMS-1:0] vld_q;
	logic [TIME_W-1:0]    free_s1;
	logic [CNT_W-1:0]     count_s1;
	logic                 vld_s1;

	// memory write and registered read
	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			free_mem[wr_addr]  <= wr_free;
			count_mem[wr_addr] <= wr_count;
		end
		free_s1  <= free_mem[rd_addr];
		count_s1 <= count_mem[rd_addr];
	end

	// valid bits: set on write, all dropped on clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (ctl.clr) begin
				vld_q <= '0;
			end else if (ctl.wr) begin
				vld_q[wr_addr] <= 1'b1;
			end
			vld_s1 <= vld_q[rd_addr];
		end
	end

	assign rd_free  = vld_s1 ? free_s1 : '0;
	assign rd_count = vld_s1 ? count_s1 : '0;

endmodule

[rtl/meeting_room_allocator.sv]
// ----------------------------------------------------------------------------
// Meeting room allocator
// Gives each well-formed meeting request a room, walking the room store one entry a cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_ready (begin_time, end_time, last_meeting),
//   in ascending start order. Results leave on out_valid/out_ready, one per
//   request. cfg_we/cfg_wdata set the number of rooms in use; write it only
//   while the block is idle.
//   An accepted request walks the rooms in use, picks a room and writes it
//   back; a last-marked request then walks the rooms for the most-booked
//   count. A rejected request goes straight to its result (after the count
//   walk when last-marked). Both walks share the single room store read port,
//   one room per cycle; one request is in work at a time, so in_ready is low
//   from accept until the result is loaded into the output register.
//   The output register holds a finished result while the receiver stalls;
//   the next request may be accepted and worked on meanwhile, and finishes
//   only once the output register is free.
//   Reset clears every room entry, the previous start and out_valid, and
//   sets the room count to 16. A last-marked request clears the room store.
// ----------------------------------------------------------------------------
module meeting_room_allocator #(
	parameter int NUM_ROOMS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [mra_pkg::RC_W-1:0]   cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [mra_pkg::REQ_W-1:0]  begin_time,
	input  logic [mra_pkg::REQ_W-1:0]  end_time,
	input  logic                       last_meeting,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [3:0]                 room,
	output logic [mra_pkg::TIME_W-1:0] actual_start,
	output logic [mra_pkg::TIME_W-1:0] actual_end,
	output logic                       delayed,
	output logic [1:0]                 error_code,
	output logic                       batch_done,
	output logic [3:0]                 most_booked_room,
	output logic [mra_pkg::CNT_W-1:0]  most_booked_count
);
	import mra_pkg::*;

	localparam int IW = (NUM_ROOMS > 1) ? $clog2(NUM_ROOMS) : 1;
	localparam int CW = $clog2(NUM_ROOMS + 1);

	state_t state_q, state_d;

	// config and request registers
	logic [RC_W-1:0]   room_count_q;
	logic [REQ_W-1:0]  prev_start_q;
	logic [REQ_W-1:0]  start_q;
	logic [REQ_W-1:0]  dur_q;
	logic              last_q;
	logic [1:0]        err_q;
	logic [1:0]        err_in;

	// walk control
	logic [CW-1:0]     n_rooms;
	logic [CW-1:0]     idx_q;
	logic              scanning;
	logic              data_vld_s1;
	logic [IW-1:0]     data_idx_s1;
	logic              idx_end;

	// trackers
	logic              found_q;
	logic [IW-1:0]     pick_idx_q;
	logic [TIME_W-1:0] pick_free_q;
	logic [CNT_W-1:0]  pick_cnt_q;
	logic [IW-1:0]     min_idx_q;
	logic [TIME_W-1:0] min_free_q;
	logic [CNT_W-1:0]  min_cnt_q;
	logic [IW-1:0]     best_idx_q;
	logic [CNT_W-1:0]  best_cnt_q;

	// result being built
	logic [IW-1:0]     sel_idx_q;
	logic [CNT_W-1:0]  sel_cnt_q;
	logic [TIME_W-1:0] res_start_q;
	logic [TIME_W-1:0] res_end_q;
	logic              res_delayed_q;
	logic              res_booked_q;

	// output register
	logic              out_valid_q;
	logic [3:0]        room_q;
	logic [TIME_W-1:0] actual_start_q;
	logic [TIME_W-1:0] actual_end_q;
	logic              delayed_q;
	logic [1:0]        error_code_q;
	logic              batch_done_q;
	logic [3:0]        mb_room_q;
	logic [CNT_W-1:0]  mb_count_q;

	// store interface
	store_ctl_t        st_ctl;
	logic [TIME_W-1:0] rd_free;
	logic [CNT_W-1:0]  rd_count;
	logic [TIME_W-1:0] wr_free;
	logic [CNT_W-1:0]  wr_count;

	// datapath helpers
	logic              accept;
	logic              emit_fire;
	logic [TIME_W-1:0] start_ext;
	logic [TIME_W-1:0] sel_free;
	logic [TIME_W:0]   end_sum;
	logic [IW+3:0]     sel_idx_w;
	logic [IW+3:0]     best_idx_w;

	// rooms in use: zero acts as one, large values clip to the store size
	always_comb begin
		if (room_count_q == '0) begin
			n_rooms = CW'(1);
		end else if (32'(room_count_q) > NUM_ROOMS) begin
			n_rooms = CW'(NUM_ROOMS);
		end else begin
			n_rooms = CW'(room_count_q);
		end
	end

	// request check at accept: empty interval first, then order
	always_comb begin
		if (end_time <= begin_time) begin
			err_in = ERR_EMPTY;
		end else if (begin_time < prev_start_q) begin
			err_in = ERR_ORDER;
		end else begin
			err_in = ERR_OK;
		end
	end

	assign accept    = in_valid && in_ready;
	assign idx_end   = (idx_q == n_rooms);
	assign start_ext = {{(TIME_W - REQ_W){1'b0}}, start_q};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (err_in == ERR_OK) begin
						state_d = ST_SCAN;
					end else if (last_meeting) begin
						state_d = ST_MSCAN;
					end else begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_SCAN: begin
				if (idx_end) begin
					state_d = ST_CALC;
				end
			end
			ST_CALC: begin
				state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				state_d = last_q ? ST_MSCAN : ST_EMIT;
			end
			ST_MSCAN: begin
				if (idx_end) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready   = 1'b0;
		scanning   = 1'b0;
		emit_fire  = 1'b0;
		st_ctl.wr  = 1'b0;
		st_ctl.clr = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_SCAN, ST_MSCAN: begin
				scanning = 1'b1;
			end
			ST_CALC: begin
			end
			ST_UPDATE: begin
				st_ctl.wr = 1'b1;
			end
			ST_EMIT: begin
				emit_fire  = !out_valid_q || out_ready;
				st_ctl.clr = emit_fire && last_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			room_count_q <= ROOM_COUNT_RST;
		end else if (cfg_we) begin
			room_count_q <= cfg_wdata;
		end
	end

	// walk counter and read-data tag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			data_vld_s1 <= 1'b0;
		end else begin
			idx_q       <= (scanning && !idx_end) ? idx_q + CW'(1) : '0;
			data_vld_s1 <= scanning && !idx_end;
		end
	end

	always_ff @(posedge clk) begin
		data_idx_s1 <= idx_q[IW-1:0];
	end

	// request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			start_q <= begin_time;
			dur_q   <= end_time - begin_time;
			last_q  <= last_meeting;
			err_q   <= err_in;
		end
	end

	// previous start: updated on a placed request, cleared at batch end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_start_q <= '0;
		end else if (st_ctl.clr) begin
			prev_start_q <= '0;
		end else if (st_ctl.wr) begin
			prev_start_q <= start_q;
		end
	end

	// room walk: first free room and earliest-freeing room
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (accept) begin
			found_q <= 1'b0;
		end else if (state_q == ST_SCAN && data_vld_s1 && !found_q && rd_free <= start_ext) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN && data_vld_s1) begin
			if (!found_q && rd_free <= start_ext) begin
				pick_idx_q  <= data_idx_s1;
				pick_free_q <= rd_free;
				pick_cnt_q  <= rd_count;
			end
			if (data_idx_s1 == '0 || rd_free < min_free_q) begin
				min_idx_q  <= data_idx_s1;
				min_free_q <= rd_free;
				min_cnt_q  <= rd_count;
			end
		end
	end

	// count walk: most-booked room, lowest index on a tie
	always_ff @(posedge clk) begin
		if (state_q == ST_MSCAN && data_vld_s1) begin
			if (data_idx_s1 == '0 || rd_count > best_cnt_q) begin
				best_idx_q <= data_idx_s1;
				best_cnt_q <= rd_count;
			end
		end
	end

	// choose the room and its actual start
	assign sel_free = found_q ? pick_free_q : min_free_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			sel_idx_q     <= '0;
			res_start_q   <= '0;
			res_end_q     <= '0;
			res_delayed_q <= 1'b0;
			res_booked_q  <= 1'b0;
		end else if (state_q == ST_CALC) begin
			sel_idx_q     <= found_q ? pick_idx_q : min_idx_q;
			sel_cnt_q     <= found_q ? pick_cnt_q : min_cnt_q;
			res_start_q   <= (sel_free < start_ext) ? start_ext : sel_free;
			res_delayed_q <= !found_q;
		end else if (state_q == ST_UPDATE) begin
			res_end_q     <= wr_free;
			res_booked_q  <= 1'b1;
		end
	end

	// end time and count update, both saturating
	assign end_sum  = {1'b0, res_start_q} + {{(TIME_W + 1 - REQ_W){1'b0}}, dur_q};
	assign wr_free  = end_sum[TIME_W] ? TIME_MAX : end_sum[TIME_W-1:0];
	assign wr_count = (sel_cnt_q == CNT_MAX) ? sel_cnt_q : sel_cnt_q + CNT_W'(1);

	mra_room_store #(
		.NUM_ROOMS (NUM_ROOMS)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (st_ctl),
		.rd_addr  (idx_q[IW-1:0]),
		.wr_addr  (sel_idx_q),
		.wr_free  (wr_free),
		.wr_count (wr_count),
		.rd_free  (rd_free),
		.rd_count (rd_count)
	);

	// low four bits of room indices
	assign sel_idx_w  = {4'b0, sel_idx_q};
	assign best_idx_w = {4'b0, best_idx_q};

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			room_q         <= res_booked_q ? sel_idx_w[3:0] : 4'd0;
			actual_start_q <= res_start_q;
			actual_end_q   <= res_end_q;
			delayed_q      <= res_delayed_q;
			error_code_q   <= err_q;
			batch_done_q   <= last_q;
			mb_room_q      <= last_q ? best_idx_w[3:0] : 4'd0;
			mb_count_q     <= last_q ? best_cnt_q : '0;
		end
	end

	assign out_valid         = out_valid_q;
	assign room              = room_q;
	assign actual_start      = actual_start_q;
	assign actual_end        = actual_end_q;
	assign delayed           = delayed_q;
	assign error_code        = error_code_q;
	assign batch_done        = batch_done_q;
	assign most_booked_room  = mb_room_q;
	assign most_booked_count = mb_count_q;

endmodule

[rtl/mra_checker.sv]
// ----------------------------------------------------------------------------
// Meeting room allocator checker
// Port-level assertions on the allocator, attached by bind.
// ----------------------------------------------------------------------------
`include "meeting_room_allocator_macros.svh"

module mra_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [3:0]                 room,
	input logic [mra_pkg::TIME_W-1:0] actual_start,
	input logic [mra_pkg::TIME_W-1:0] actual_end,
	input logic                       delayed,
	input logic [1:0]                 error_code,
	input logic                       batch_done,
	input logic [3:0]                 most_booked_room,
	input logic [mra_pkg::CNT_W-1:0]  most_booked_count
);
	import mra_pkg::*;

	// a stalled result holds
	`MRA_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(room) && $stable(actual_end) && $stable(error_code), "result changed while stalled")

	// one request in work at a time
	`MRA_ASSERT_NXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready, "ready right after accept")

	// rejected request carries no placement
	`MRA_ASSERT_IMP(a_reject_zero, clk, arst_n, out_valid && error_code != ERR_OK, room == 4'd0 && actual_start == '0 && actual_end == '0 && !delayed, "rejected item has placement")

	// most-booked fields only at batch end
	`MRA_ASSERT_IMP(a_booked_zero, clk, arst_n, out_valid && !batch_done, most_booked_room == 4'd0 && most_booked_count == '0, "most-booked fields outside batch end")

	// a placed meeting ends after it starts unless saturated
	`MRA_ASSERT_IMP(a_end_after_start, clk, arst_n, out_valid && error_code == ERR_OK, actual_end > actual_start || actual_end == TIME_MAX, "meeting end not after start")

endmodule

bind meeting_room_allocator mra_checker u_mra_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.in_valid          (in_valid),
	.in_ready          (in_ready),
	.out_valid         (out_valid),
	.out_ready         (out_ready),
	.room              (room),
	.actual_start      (actual_start),
	.actual_end        (actual_end),
	.delayed           (delayed),
	.error_code        (error_code),
	.batch_done        (batch_done),
	.most_booked_room  (most_booked_room),
	.most_booked_count (most_booked_count)
);

[verif/tb_meeting_room_allocator.sv]
// ----------------------------------------------------------------------------
// Meeting room allocator testbench
// Drives meeting requests through the valid/ready input channel and checks
// every result against a room-booking predictor kept in step with each
// accepted item. A directed table covers reset, extremes, error codes and the
// room count limits, then a free-time saturation batch runs, then random
// batches of ordered requests mixed with noise, over several room counts.
// Both sides idle in random bursts, except in saturation and the last part of the run.
// ----------------------------------------------------------------------------
module tb_meeting_room_allocator;

	import mra_pkg::*;

	localparam int ROOMS          = 16;
	localparam int RANDOM_ITEMS   = 1500;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 60;
	localparam int SAT_ITEMS      = 259;

	// one result item
	typedef struct packed {
		logic [3:0]        room;
		logic [TIME_W-1:0] act_start;
		logic [TIME_W-1:0] act_end;
		logic              delayed;
		logic [1:0]        err;
		logic              done;
		logic [3:0]        top_room;
		logic [CNT_W-1:0]  top_count;
	} booking_t;

	// one row of the directed table: a room count write or a request
	typedef struct {
		logic             is_cfg;
		logic [RC_W-1:0]  cfg_val;
		logic [REQ_W-1:0] s;
		logic [REQ_W-1:0] e;
		logic             last;
		logic             typed;
		booking_t         want;
	} dir_row_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [RC_W-1:0]   cfg_wdata;
	logic              in_valid;
	logic              in_ready;
	logic [REQ_W-1:0]  begin_time;
	logic [REQ_W-1:0]  end_time;
	logic              last_meeting;
	logic              out_valid;
	logic              out_ready;
	logic [3:0]        room;
	logic [TIME_W-1:0] actual_start;
	logic [TIME_W-1:0] actual_end;
	logic              delayed;
	logic [1:0]        error_code;
	logic              batch_done;
	logic [3:0]        most_booked_room;
	logic [CNT_W-1:0]  most_booked_count;

	// predictor state
	logic [TIME_W-1:0] free_at [ROOMS];
	logic [CNT_W-1:0]  meetings [ROOMS];
	logic [REQ_W-1:0]  last_start;
	logic [RC_W-1:0]   rooms_cfg;

	booking_t pending_bookings[$];
	dir_row_t dir_rows[$];
	int       errors;
	int       gap_pct;
	int       batch_left;
	bit       base_pending;
	int       quiet_cycles;

	meeting_room_allocator uut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_wdata         (cfg_wdata),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.begin_time        (begin_time),
		.end_time          (end_time),
		.last_meeting      (last_meeting),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.room              (room),
		.actual_start      (actual_start),
		.actual_end        (actual_end),
		.delayed           (delayed),
		.error_code        (error_code),
		.batch_done        (batch_done),
		.most_booked_room  (most_booked_room),
		.most_booked_count (most_booked_count)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------
	function automatic void clear_rooms();
		for (int i = 0; i < ROOMS; i++) begin
			free_at[i]  = '0;
			meetings[i] = '0;
		end
		last_start = '0;
	endfunction

	function automatic booking_t book_meeting(input logic [REQ_W-1:0] s,
			input logic [REQ_W-1:0] e, input logic last);
		booking_t          r;
		int                n;
		int                pick;
		int                best;
		bit                found;
		logic [TIME_W-1:0] s_wide;
		logic [TIME_W-1:0] st;
		logic [TIME_W:0]   sum;
		r = '0;
		n = (rooms_cfg == 0) ? 1 : (rooms_cfg > ROOMS) ? ROOMS : int'(rooms_cfg);
		s_wide = {{(TIME_W-REQ_W){1'b0}}, s};
		// empty interval wins over order
		if (e <= s)
			r.err = ERR_EMPTY;
		else if (s < last_start)
			r.err = ERR_ORDER;
		else
			r.err = ERR_OK;
		if (r.err == ERR_OK) begin
			found = 1'b0;
			pick  = 0;
			// first room already free at the requested start
			for (int i = 0; i < n; i++) begin
				if (!found && free_at[i] <= s_wide) begin
					pick  = i;
					found = 1'b1;
				end
			end
			// none free: earliest to free, lowest index on a tie
			if (!found) begin
				for (int i = 1; i < n; i++)
					if (free_at[i] < free_at[pick])
						pick = i;
			end
			st  = (free_at[pick] > s_wide) ? free_at[pick] : s_wide;
			sum = {1'b0, st} + {{(TIME_W-REQ_W+1){1'b0}}, e - s};
			r.act_end   = (sum > {1'b0, TIME_MAX}) ? TIME_MAX : sum[TIME_W-1:0];
			r.room      = pick[3:0];
			r.act_start = st;
			r.delayed   = !found;
			free_at[pick] = r.act_end;
			if (meetings[pick] != CNT_MAX)
				meetings[pick] = meetings[pick] + 1'b1;
			last_start = s;
		end
		// batch end: report after counting, then wipe the store
		if (last) begin
			best = 0;
			for (int i = 1; i < n; i++)
				if (meetings[i] > meetings[best])
					best = i;
			r.done      = 1'b1;
			r.top_room  = best[3:0];
			r.top_count = meetings[best];
			clear_rooms();
		end
		return r;
	endfunction

	// append to the expected-result queue and the directed table
	function automatic void queue_booking(input booking_t b);
		pending_bookings.insert(pending_bookings.size(), b);
	endfunction

	function automatic void add_row(input dir_row_t r);
		dir_rows.insert(dir_rows.size(), r);
	endfunction

	// ------------------------------------------------------------------
	// Directed table rows
	// ------------------------------------------------------------------
	function automatic dir_row_t cfg_row(input logic [RC_W-1:0] v);
		dir_row_t r;
		r.is_cfg  = 1'b1;
		r.cfg_val = v;
		r.s       = '0;
		r.e       = '0;
		r.last    = 1'b0;
		r.typed   = 1'b0;
		r.want    = '0;
		return r;
	endfunction

	function automatic dir_row_t pred_row(input logic [REQ_W-1:0] s,
			input logic [REQ_W-1:0] e, input logic last);
		dir_row_t r;
		r = cfg_row('0);
		r.is_cfg = 1'b0;
		r.s      = s;
		r.e      = e;
		r.last   = last;
		return r;
	endfunction

	function automatic dir_row_t typed_row(input logic [REQ_W-1:0] s,
			input logic [REQ_W-1:0] e, input logic last, input logic [3:0] rm,
			input logic [TIME_W-1:0] st, input logic [TIME_W-1:0] en,
			input logic dly, input logic [1:0] err, input logic done,
			input logic [3:0] trm, input logic [CNT_W-1:0] tcnt);
		dir_row_t r;
		r = pred_row(s, e, last);
		r.typed          = 1'b1;
		r.want.room      = rm;
		r.want.act_start = st;
		r.want.act_end   = en;
		r.want.delayed   = dly;
		r.want.err       = err;
		r.want.done      = done;
		r.want.top_room  = trm;
		r.want.top_count = tcnt;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------
	task automatic push_request(input logic [REQ_W-1:0] s, input logic [REQ_W-1:0] e,
			input logic last);
		int gap;
		gap = (gap_pct > 0 && $urandom_range(1, 100) <= gap_pct) ? $urandom_range(1, 12) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid     <= 1'b1;
		begin_time   <= s;
		end_time     <= e;
		last_meeting <= last;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic release_input();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// room count write, only once every result is back
	task automatic set_room_count(input logic [RC_W-1:0] v);
		release_input();
		while (pending_bookings.size() != 0) @(posedge clk);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		rooms_cfg = v;
	endtask

	// next random request: mostly ordered batches, some noise and broken items
	task automatic gen_request(output logic [REQ_W-1:0] s, output logic [REQ_W-1:0] e,
			output logic last);
		int            kind;
		logic [REQ_W:0] t;
		logic [REQ_W-1:0] dur;
		logic [REQ_W-1:0] inc;
		if (batch_left == 0) begin
			batch_left   = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
			                                           : $urandom_range(1, 30);
			base_pending = 1'b1;
		end
		case ($urandom_range(0, 9))
			0: begin
				dur = $urandom;
			end
			1: begin
				dur = $urandom_range(1, 5000);
			end
			default: begin
				dur = $urandom_range(1, 40);
			end
		endcase
		kind = $urandom_range(0, 99);
		if (kind < 6) begin
			// raw noise
			s = $urandom;
			e = $urandom;
		end else if (kind < 10) begin
			// starts before the previous one
			s = last_start - $urandom_range(1, 50);
			e = s + dur;
		end else if (kind < 13) begin
			// empty interval
			s = last_start + $urandom_range(0, 20);
			e = s - $urandom_range(0, 3);
		end else begin
			if (base_pending) begin
				case ($urandom_range(0, 9))
					6, 7: s = $urandom;
					8: s = 32'hFFFF_FFFF - $urandom_range(0, 5000);
					default: s = $urandom_range(0, 1000);
				endcase
				base_pending = 1'b0;
			end else begin
				case ($urandom_range(0, 9))
					0, 1: inc = '0;
					7, 8: inc = $urandom_range(1, 300);
					9: inc = $urandom_range(1, 1 << 20);
					default: inc = $urandom_range(1, 10);
				endcase
				t = {1'b0, last_start} + inc;
				s = t[REQ_W] ? last_start : t[REQ_W-1:0];
			end
			t = {1'b0, s} + dur;
			e = t[REQ_W] ? 32'hFFFF_FFFF : t[REQ_W-1:0];
		end
		batch_left--;
		last = (batch_left == 0);
	endtask

	// ------------------------------------------------------------------
	// Output side: ready with random stall bursts
	// ------------------------------------------------------------------
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (gap_pct > 0 && $urandom_range(1, 100) <= gap_pct) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	// compare each result item with the oldest booking expected
	always @(posedge clk) begin : result_check
		booking_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_bookings.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual room %0h err %0h",
					$time, room, error_code);
			end else begin
				want = pending_bookings.pop_front();
				check_field("room", want.room, room);
				check_field("actual_start", want.act_start, actual_start);
				check_field("actual_end", want.act_end, actual_end);
				check_field("delayed", want.delayed, delayed);
				check_field("error_code", want.err, error_code);
				check_field("batch_done", want.done, batch_done);
				check_field("most_booked_room", want.top_room, most_booked_room);
				check_field("most_booked_count", want.top_count, most_booked_count);
			end
		end
	end

	// watchdog on cycles with no item moving on either side
	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("%0t: watchdog expired", $time);
		$display("Verification failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin : main_seq
		int               sent;
		int               phase_len;
		logic [REQ_W-1:0] s;
		logic [REQ_W-1:0] e;
		logic             l;
		logic [RC_W-1:0]  rc;
		booking_t         got;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		in_valid     = 1'b0;
		begin_time   = '0;
		end_time     = '0;
		last_meeting = 1'b0;
		errors       = 0;
		gap_pct      = 25;
		batch_left   = 0;
		base_pending = 1'b0;
		clear_rooms();
		rooms_cfg = ROOM_COUNT_RST;

		// directed table, room count 16 from reset
		add_row(typed_row(32'd0, 32'd1, 1'b0, 4'd0, 40'd0, 40'd1,
			1'b0, ERR_OK, 1'b0, 4'd0, 32'd0));
		add_row(typed_row(32'd5, 32'd5, 1'b0, 4'd0, 40'd0, 40'd0,
			1'b0, ERR_EMPTY, 1'b0, 4'd0, 32'd0));
		add_row(typed_row(32'd10, 32'd3, 1'b0, 4'd0, 40'd0, 40'd0,
			1'b0, ERR_EMPTY, 1'b0, 4'd0, 32'd0));
		add_row(typed_row(32'd100, 32'd200, 1'b0, 4'd0, 40'd100, 40'd200,
			1'b0, ERR_OK, 1'b0, 4'd0, 32'd0));
		add_row(typed_row(32'd50, 32'd60, 1'b0, 4'd0, 40'd0, 40'd0,
			1'b0, ERR_ORDER, 1'b0, 4'd0, 32'd0));
		// both empty and out of order: empty is reported
		add_row(typed_row(32'd40, 32'd30, 1'b0, 4'd0, 40'd0, 40'd0,
			1'b0, ERR_EMPTY, 1'b0, 4'd0, 32'd0));
		add_row(pred_row(32'd100, 32'd300, 1'b0));
		// rejected request still closes the batch
		add_row(pred_row(32'd100, 32'd100, 1'b1));
		add_row(typed_row(32'd0, 32'hFFFF_FFFF, 1'b0, 4'd0, 40'd0,
			40'h00_FFFF_FFFF, 1'b0, ERR_OK, 1'b0, 4'd0, 32'd0));
		add_row(typed_row(32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b1, 4'd1,
			40'h00_FFFF_FFFE, 40'h00_FFFF_FFFF, 1'b0, ERR_OK, 1'b1, 4'd0, 32'd1));
		// empty batch: nothing booked
		add_row(typed_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 4'd0, 40'd0,
			40'd0, 1'b0, ERR_EMPTY, 1'b1, 4'd0, 32'd0));
		// one room: every overlap is delayed
		add_row(cfg_row(5'd1));
		add_row(pred_row(32'd0, 32'd10, 1'b0));
		add_row(pred_row(32'd0, 32'd10, 1'b0));
		add_row(pred_row(32'd5, 32'd6, 1'b1));
		// zero acts as one room; long meetings push past 32 bits
		add_row(cfg_row(5'd0));
		add_row(pred_row(32'd0, 32'hFFFF_FFFF, 1'b0));
		add_row(pred_row(32'd0, 32'hFFFF_FFFF, 1'b0));
		add_row(pred_row(32'd7, 32'hFFFF_FFFF, 1'b1));
		// count above the room total acts as all rooms
		add_row(cfg_row(5'd31));
		add_row(pred_row(32'd3, 32'd9, 1'b0));
		add_row(pred_row(32'd3, 32'd9, 1'b0));
		add_row(pred_row(32'd3, 32'd9, 1'b0));
		add_row(pred_row(32'd9, 32'd10, 1'b1));
		// two rooms freeing together: lowest index wins
		add_row(cfg_row(5'd2));
		add_row(pred_row(32'd0, 32'd10, 1'b0));
		add_row(pred_row(32'd0, 32'd10, 1'b0));
		add_row(pred_row(32'd1, 32'd2, 1'b0));
		add_row(pred_row(32'd1, 32'd0, 1'b1));

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg) begin
				set_room_count(dir_rows[i].cfg_val);
			end else begin
				push_request(dir_rows[i].s, dir_rows[i].e, dir_rows[i].last);
				got = book_meeting(dir_rows[i].s, dir_rows[i].e, dir_rows[i].last);
				queue_booking(dir_rows[i].typed ? dir_rows[i].want : got);
			end
		end

		// free-time saturation: one room, back-to-back full-range meetings
		set_room_count(5'd1);
		gap_pct = 0;
		for (int k = 1; k <= SAT_ITEMS; k++) begin
			l = (k == SAT_ITEMS);
			push_request(32'd0, 32'hFFFF_FFFF, l);
			queue_booking(book_meeting(32'd0, 32'hFFFF_FFFF, l));
		end

		// random phases, each with its own room count and idling density
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0: rc = 5'd0;
				1: rc = 5'd1;
				2: rc = 5'd16;
				3: rc = $urandom_range(17, 31);
				default: rc = $urandom_range(2, 15);
			endcase
			set_room_count(rc);
			if (sent >= RANDOM_ITEMS * 85 / 100) begin
				gap_pct = 0;
			end else begin
				case ($urandom_range(0, 2))
					0: gap_pct = 0;
					1: gap_pct = 10;
					default: gap_pct = 45;
				endcase
			end
			phase_len = $urandom_range(20, 80);
			repeat (phase_len) begin
				gen_request(s, e, l);
				push_request(s, e, l);
				queue_booking(book_meeting(s, e, l));
				sent++;
			end
		end

		// drain, then let any stray result show up
		release_input();
		while (pending_bookings.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

[files.f]
+incdir+rtl
rtl/mra_pkg.sv
rtl/mra_room_store.sv
rtl/meeting_room_allocator.sv
rtl/mra_checker.sv
verif/tb_meeting_room_allocator.sv
